// ----- design/miller_rabin_prime_test_64_assert.svh -----
// Assertion macros for the primality tester.
// Included by the modules that carry assertions.
`ifndef MILLER_RABIN_PRIME_TEST_64_ASSERT_SVH
`define MILLER_RABIN_PRIME_TEST_64_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define MR_ASSERT_IMP(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("assertion failed");
`define MR_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed");
`else
`define MR_ASSERT_IMP(label, clk, rst_n, pre, post)
`define MR_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

// ----- design/mrpt_pkg.sv -----
// Shared types and constants for the primality tester.
// No dependencies.
package mrpt_pkg;
	localparam int Width = 64;
	localparam int NumBases = 25;
	localparam int BitW = $clog2(Width);
	localparam int BaseIdxW = 5;

	typedef logic [Width-1:0] word_t;

	function automatic logic [6:0] base_value(input logic [BaseIdxW-1:0] idx);
		logic [6:0] v;
		case (idx)
			5'd0: v = 7'd2;    5'd1: v = 7'd3;    5'd2: v = 7'd5;    5'd3: v = 7'd7;
			5'd4: v = 7'd11;   5'd5: v = 7'd13;   5'd6: v = 7'd17;   5'd7: v = 7'd19;
			5'd8: v = 7'd23;   5'd9: v = 7'd29;   5'd10: v = 7'd31;  5'd11: v = 7'd37;
			5'd12: v = 7'd41;  5'd13: v = 7'd43;  5'd14: v = 7'd47;  5'd15: v = 7'd53;
			5'd16: v = 7'd59;  5'd17: v = 7'd61;  5'd18: v = 7'd67;  5'd19: v = 7'd71;
			5'd20: v = 7'd73;  5'd21: v = 7'd79;  5'd22: v = 7'd83;  5'd23: v = 7'd89;
			5'd24: v = 7'd97;
			default: v = 7'd2;
		endcase
		return v;
	endfunction
endpackage

// ----- design/mrpt_mulmod.sv -----
// Bit-serial modular multiplier: one double-and-add step per cycle.
// Depends on mrpt_pkg.
module mrpt_mulmod (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  mrpt_pkg::word_t    x,
	input  mrpt_pkg::word_t    y,
	input  mrpt_pkg::word_t    m,
	output logic               done,
	output mrpt_pkg::word_t    prod
);
	logic                       busy_q;
	logic [mrpt_pkg::BitW-1:0]  bit_q;
	mrpt_pkg::word_t            acc_q, x_q, y_q, m_q;
	mrpt_pkg::word_t            dbl, room1, room2, sum2;
	logic                       last;

	// acc = 2*acc mod m, then + x mod m if the bit is set
	always_comb begin
		room1 = m_q - acc_q;
		dbl   = (acc_q >= room1) ? (acc_q - room1) : (acc_q + acc_q);
		room2 = m_q - x_q;
		sum2  = (dbl >= room2) ? (dbl - room2) : (dbl + x_q);
	end
	assign last = (bit_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			bit_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				bit_q  <= mrpt_pkg::BitW'(mrpt_pkg::Width - 1);
			end else if (busy_q) begin
				bit_q <= bit_q - 1'b1;
				if (last) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			x_q   <= x;
			y_q   <= y;
			m_q   <= m;
		end else if (busy_q) begin
			acc_q <= y_q[bit_q] ? sum2 : dbl;
		end
	end
	assign prod = acc_q;

	`include "miller_rabin_prime_test_64_assert.svh"
	`MR_ASSERT_NEXT(a_done_pulse, clk, arst_n, done, !done)
	`MR_ASSERT_NEXT(a_start_busy, clk, arst_n, start, busy_q && !done)
	`MR_ASSERT_IMP(a_done_idle, clk, arst_n, done, !busy_q)
endmodule

// ----- design/miller_rabin_prime_test_64.sv -----
// Top level of the 64-bit deterministic Miller-Rabin primality tester.
// Depends on mrpt_pkg and mrpt_mulmod.
//
//  channel | signals                              | direction
//  input   | in_valid, in_stall, candidate[63:0]  | beat in
//  output  | out_valid, out_stall, is_prime       | beat out
//
// One beat at a time; in_stall is high from acceptance until the result is taken.
// Each modular product runs on the shared serial multiplier; the sequencer passes
// through ST_PSTEP for each exponent bit and through ST_SQ for each witness square;
// inputs below 4 go straight from ST_IDLE to ST_OUT.
// Reset clears the sequencer; no clearing pass. out_stall only holds the result.
module miller_rabin_prime_test_64 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] candidate,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        is_prime
);
	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_SPLIT = 4'd1;
	localparam logic [3:0] ST_BASE  = 4'd2;
	localparam logic [3:0] ST_PSTEP = 4'd3;
	localparam logic [3:0] ST_PMUL  = 4'd4;
	localparam logic [3:0] ST_PSQ   = 4'd5;
	localparam logic [3:0] ST_CHECK = 4'd6;
	localparam logic [3:0] ST_SQ    = 4'd7;
	localparam logic [3:0] ST_SQW   = 4'd8;
	localparam logic [3:0] ST_OUT   = 4'd9;

	logic [3:0]                      state_q;
	mrpt_pkg::word_t                 n_q, nm1_q, d_q, e_q, b_q, acc_q;
	logic [mrpt_pkg::BitW-1:0]       s_q, r_q;
	logic [mrpt_pkg::BaseIdxW-1:0]   idx_q;
	logic                            res_q;
	logic                            mul_start, mul_done;
	mrpt_pkg::word_t                 mul_x, mul_y, mul_p;
	mrpt_pkg::word_t                 base_w;

	assign base_w = mrpt_pkg::word_t'(mrpt_pkg::base_value(idx_q));

	mrpt_mulmod u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start),
		.x(mul_x), .y(mul_y), .m(n_q), .done(mul_done), .prod(mul_p)
	);

	always_comb begin
		mul_start = 1'b0;
		mul_x = b_q;
		mul_y = b_q;
		case (state_q)
			ST_PSTEP: begin
				// odd bit: acc * b first; even bit: straight to the square
				mul_start = (e_q != '0);
				mul_x = e_q[0] ? acc_q : b_q;
				mul_y = b_q;
			end
			ST_PMUL: begin
				mul_start = mul_done;
			end
			ST_SQ: begin
				mul_start = 1'b1;
				mul_x = acc_q;
				mul_y = acc_q;
			end
			default: ;
		endcase
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign is_prime  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (in_valid) begin
					if (candidate < 64'd4) state_q <= ST_OUT;
					else state_q <= ST_SPLIT;
				end
				ST_SPLIT: if (d_q[0]) state_q <= ST_BASE;
				ST_BASE: begin
					if (base_w == n_q) state_q <= ST_OUT;
					else state_q <= ST_PSTEP;
				end
				ST_PSTEP: begin
					if (e_q == '0) state_q <= ST_CHECK;
					else if (e_q[0]) state_q <= ST_PMUL;
					else state_q <= ST_PSQ;
				end
				ST_PMUL: if (mul_done) state_q <= ST_PSQ;
				ST_PSQ: if (mul_done) state_q <= ST_PSTEP;
				ST_CHECK: begin
					if (acc_q == 64'd1 || acc_q == nm1_q) begin
						if (idx_q == mrpt_pkg::BaseIdxW'(mrpt_pkg::NumBases - 1))
							state_q <= ST_OUT;
						else state_q <= ST_BASE;
					end else if (r_q >= s_q) begin
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_SQ;
					end
				end
				ST_SQ: state_q <= ST_SQW;
				ST_SQW: if (mul_done) state_q <= ST_CHECK;
				ST_OUT: if (!out_stall) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath; pow_mod's square launch shares the unit after the conditional multiply
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				n_q   <= candidate;
				nm1_q <= candidate - 64'd1;
				d_q   <= candidate - 64'd1;
				s_q   <= '0;
				idx_q <= '0;
				res_q <= (candidate == 64'd2) || (candidate == 64'd3);
			end
			ST_SPLIT: if (!d_q[0]) begin
				d_q <= d_q >> 1;
				s_q <= s_q + 1'b1;
			end
			ST_BASE: begin
				res_q <= 1'b1;
				b_q   <= base_w;
				e_q   <= d_q;
				acc_q <= 64'd1;
				r_q   <= mrpt_pkg::BitW'(1);
			end
			ST_PMUL: if (mul_done) acc_q <= mul_p;
			ST_PSQ: if (mul_done) begin
				b_q <= mul_p;
				e_q <= e_q >> 1;
			end
			ST_CHECK: begin
				if (acc_q == 64'd1 || acc_q == nm1_q) idx_q <= idx_q + 1'b1;
				else if (r_q >= s_q) res_q <= 1'b0;
				// after a square, a result of 1 can no longer reach n-1
			end
			ST_SQW: if (mul_done) begin
				acc_q <= (mul_p == 64'd1) ? 64'd0 : mul_p;
				r_q   <= r_q + 1'b1;
			end
			default: ;
		endcase
	end

	`include "miller_rabin_prime_test_64_assert.svh"
	`MR_ASSERT_IMP(a_out_only_done, clk, arst_n, out_valid, in_stall)
	`MR_ASSERT_NEXT(a_hold_res, clk, arst_n, out_valid && out_stall, out_valid && $stable(is_prime))
	`MR_ASSERT_NEXT(a_accept_busy, clk, arst_n, in_valid && !in_stall, in_stall)
endmodule
